### hdl/swptm_pkg.sv
// Shared types and constants of the sliding-window phase time monitor.
// Used by every module of the block but swptm_ram; depends on nothing.
`timescale 1ns / 1ps
package swptm_pkg;

  localparam int unsigned NPHASE   = 6;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned TIME_W   = 31;
  localparam int unsigned CUR_W    = 36;
  localparam int unsigned NUM_CFG  = 4;
  localparam int unsigned ADDR_W   = 4;
  localparam logic [TIME_W-1:0] MAX31 = '1;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_LEN_A = 2'd0;
  localparam logic [1:0] REG_LEN_B = 2'd1;
  localparam logic [1:0] REG_LEN_C = 2'd2;
  localparam logic [1:0] REG_LEN_D = 2'd3;

  localparam logic [TIME_W-1:0] LEN_A_RST = 31'd10;
  localparam logic [TIME_W-1:0] LEN_B_RST = 31'd50;
  localparam logic [TIME_W-1:0] LEN_C_RST = 31'd100;
  localparam logic [TIME_W-1:0] LEN_D_RST = 31'd1000;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  dur_real;
    logic [TIME_W-1:0]  dur_cpu;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         window_index;
    logic [PHASE_W-1:0] phase_index;
    logic [TIME_W-1:0]  cur_real;
    logic [TIME_W-1:0]  lo_real;
    logic [TIME_W-1:0]  hi_real;
    logic [TIME_W-1:0]  cur_cpu;
    logic [TIME_W-1:0]  min_cpu;
    logic [TIME_W-1:0]  max_cpu;
    logic               window_full;
    logic               log_overflow;
    logic               last_row;
  } result_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    cmd_t cmd;
    logic known;
  } queue_item_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  t_real;
    logic [TIME_W-1:0]  t_cpu;
  } log_entry_t;

  // Queue-to-back handshake
  typedef struct packed {
    logic        valid;
    queue_item_t item;
  } queue_out_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_APPEND = 7'b0000010,
    ST_INIT   = 7'b0000100,
    ST_READ   = 7'b0001000,
    ST_EVAL   = 7'b0010000,
    ST_UPDATE = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } back_state_e;

  function automatic logic [TIME_W-1:0] clamp31(input logic signed [CUR_W-1:0] v);
    logic [TIME_W-1:0] r;
    if (v < 0) r = '0;
    else if (v > $signed({5'b0, MAX31})) r = MAX31;
    else r = v[TIME_W-1:0];
    return r;
  endfunction

endpackage

### hdl/sliding_window_phase_time_monitor_top.sv
// Top level of the sliding-window phase time monitor: window length registers,
// front queue and back sequencer. Depends on swptm_pkg, swptm_front, swptm_back.
//
//   channel   handshake                       payload
//   -------   -----------------------------   ---------------------------
//   input     start high, busy low            cmd_i (phase, elapsed times)
//   result    result_valid_o, one cycle each  result_o (one report row)
//   config    psel & penable & pwrite         paddr, pwdata / prdata
//
// An item waits in the queue until the back picks it up; then the back appends
// it, runs per window and time domain an init step plus a read and an evaluate
// step per log entry visited (registered log read), updates min/max and emits
// 6*WINDOW_COUNT rows. An ignored or overflowing item goes straight to the rows.
// busy stays high from acceptance to the last row; rows cannot be stalled.
// Reset clears all control state at once; the log needs no clearing pass.
`timescale 1ns / 1ps
module sliding_window_phase_time_monitor_top #(
  parameter int unsigned LOG_DEPTH    = 1024,
  parameter int unsigned WINDOW_COUNT = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  swptm_pkg::cmd_t     cmd_i,
  output logic                result_valid_o,
  output swptm_pkg::result_t  result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [swptm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import swptm_pkg::*;

  logic [TIME_W-1:0] len_q [NUM_CFG];
  logic              cfg_we;
  logic [1:0]        reg_sel;
  logic              back_busy, pop;
  queue_out_t        q;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite;

  // Window length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[REG_LEN_A] <= LEN_A_RST;
      len_q[REG_LEN_B] <= LEN_B_RST;
      len_q[REG_LEN_C] <= LEN_C_RST;
      len_q[REG_LEN_D] <= LEN_D_RST;
    end else if (cfg_we) begin
      len_q[reg_sel] <= pwdata[TIME_W-1:0];
    end
  end

  assign prdata = {1'b0, len_q[reg_sel]};

  swptm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd_i),
    .back_busy_i (back_busy),
    .pop_i       (pop),
    .q_o         (q),
    .busy_o      (busy)
  );

  swptm_back #(
    .LOG_DEPTH    (LOG_DEPTH),
    .WINDOW_COUNT (WINDOW_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_i            (q),
    .pop_o          (pop),
    .busy_o         (back_busy),
    .win_len_i      (len_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### hdl/swptm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module swptm_ram #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/swptm_front.sv
// Front end: accepts items, classifies the phase code, queues them for the back.
// Depends on swptm_pkg.
`timescale 1ns / 1ps
module swptm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  swptm_pkg::cmd_t      cmd_i,
  input  logic                 back_busy_i,
  input  logic                 pop_i,
  output swptm_pkg::queue_out_t q_o,
  output logic                 busy_o
);
  import swptm_pkg::*;

  queue_item_t slot_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;

  assign busy_o = (count_q != 2'd0) || back_busy_i;
  assign push   = start_i && !busy_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the item with its class: a code past the last phase is ignored
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q].cmd   <= cmd_i;
      slot_q[wr_ptr_q].known <= (cmd_i.phase < PHASE_W'(NPHASE));
    end
  end

  assign q_o.valid = (count_q != 2'd0);
  assign q_o.item  = slot_q[rd_ptr_q];

endmodule

### hdl/swptm_back.sv
// Back end: appends to the log, slides every window, tracks min/max, emits rows.
// Depends on swptm_pkg and swptm_ram.
`timescale 1ns / 1ps
module swptm_back #(
  parameter int unsigned LOG_DEPTH    = 1024,
  parameter int unsigned WINDOW_COUNT = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swptm_pkg::queue_out_t   q_i,
  output logic                    pop_o,
  output logic                    busy_o,
  input  logic [30:0]             win_len_i [swptm_pkg::NUM_CFG],
  output logic                    result_valid_o,
  output swptm_pkg::result_t      result_o
);
  import swptm_pkg::*;

  localparam int unsigned AW = $clog2(LOG_DEPTH);
  localparam int unsigned NE = WINDOW_COUNT * NPHASE;
  localparam int unsigned NW = $clog2(NE);
  localparam int unsigned WW = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
  localparam int unsigned UW = 34;

  back_state_e state_q, state_d;

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] sidx_q [2][WINDOW_COUNT];
  logic [AW-1:0] sidx_d [2][WINDOW_COUNT];
  logic          sval_q [2][WINDOW_COUNT];
  logic          sval_d [2][WINDOW_COUNT];
  logic [TIME_W-1:0] soff_q [2][WINDOW_COUNT];
  logic [TIME_W-1:0] soff_d [2][WINDOW_COUNT];
  logic signed [CUR_W-1:0] cur_q [2][NE];
  logic signed [CUR_W-1:0] cur_d [2][NE];
  logic [TIME_W-1:0] min_q [2][NE];
  logic [TIME_W-1:0] min_d [2][NE];
  logic [TIME_W-1:0] max_q [2][NE];
  logic [TIME_W-1:0] max_d [2][NE];

  cmd_t          item_q, item_d;
  logic          ovf_q, ovf_d;
  logic [WW-1:0] w_q, w_d;
  logic          d_q, d_d;
  logic [AW-1:0] i_q, i_d;
  logic [UW-1:0] u_q, u_d;
  logic          addoff_q, addoff_d;
  logic [AW:0]   best_q, best_d;
  logic [AW-1:0] newhead_q, newhead_d;
  logic          have_q, have_d;
  logic [NW-1:0] row_q, row_d;
  logic [WW-1:0] rw_q, rw_d;
  logic [PHASE_W-1:0] rp_q, rp_d;

  logic          ram_we;
  log_entry_t    ram_wdata, ram_rdata;

  // Per-step working values
  logic [TIME_W-1:0]  size, nv, off, e;
  logic [PHASE_W-1:0] eph;
  logic [AW-1:0]      last, cand;
  logic [AW:0]        age;
  logic [UW-1:0]      u_new, u_less;
  logic               cont, slide_done;
  logic signed [CUR_W-1:0] delta;
  logic [NW-1:0]      k;
  logic [TIME_W-1:0]  c;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] x);
    return (x == AW'(LOG_DEPTH - 1)) ? '0 : x + AW'(1);
  endfunction

  function automatic logic [NW-1:0] idx_of(input logic [WW-1:0] w, input logic [PHASE_W-1:0] p);
    return NW'(NW'(w) * NW'(NPHASE) + NW'(p));
  endfunction

  swptm_ram #(
    .WIDTH ($bits(log_entry_t)),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .raddr_i (i_q),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata.phase  = item_q.phase;
  assign ram_wdata.t_real = item_q.dur_real;
  assign ram_wdata.t_cpu  = item_q.dur_cpu;

  // Window length, new time and start offset of the slide in progress
  assign size = (32'(w_q) < NUM_CFG) ? win_len_i[2'(w_q)] : win_len_i[NUM_CFG-1];
  assign nv   = d_q ? item_q.dur_cpu : item_q.dur_real;
  assign off  = soff_q[d_q][w_q];
  assign e    = d_q ? ram_rdata.t_cpu : ram_rdata.t_real;
  assign eph  = (ram_rdata.phase >= PHASE_W'(NPHASE)) ?
                ram_rdata.phase - PHASE_W'(NPHASE) : ram_rdata.phase;
  assign last = (tail_q == '0) ? AW'(LOG_DEPTH - 1) : tail_q - AW'(1);
  assign cont = (i_q != last) && (u_q >= UW'(e) + UW'(size));
  assign u_less = u_q - UW'(size);
  assign k    = idx_of(w_q, eph);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    sidx_d    = sidx_q;
    sval_d    = sval_q;
    soff_d    = soff_q;
    cur_d     = cur_q;
    min_d     = min_q;
    max_d     = max_q;
    item_d    = item_q;
    ovf_d     = ovf_q;
    w_d       = w_q;
    d_d       = d_q;
    i_d       = i_q;
    u_d       = u_q;
    addoff_d  = addoff_q;
    best_d    = best_q;
    newhead_d = newhead_q;
    have_d    = have_q;
    row_d     = row_q;
    rw_d      = rw_q;
    rp_d      = rp_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    slide_done = 1'b0;
    cand      = head_q;
    u_new     = '0;
    delta     = '0;
    c         = '0;

    case (state_q)
      // Take the next queued item and decide what it does
      ST_IDLE: begin
        if (q_i.valid) begin
          pop_o  = 1'b1;
          item_d = q_i.item.cmd;
          row_d  = '0;
          rw_d   = '0;
          rp_d   = '0;
          if (!q_i.item.known) begin
            ovf_d   = 1'b0;
            state_d = ST_EMIT;
          end else if (inc(tail_q) == head_q) begin
            ovf_d   = 1'b1;
            state_d = ST_EMIT;
          end else begin
            ovf_d   = 1'b0;
            state_d = ST_APPEND;
          end
        end
      end

      // Write the log entry and add its times to every window
      ST_APPEND: begin
        ram_we = 1'b1;
        for (int w = 0; w < WINDOW_COUNT; w++) begin
          cur_d[0][w*NPHASE + int'(item_q.phase)] =
            cur_q[0][w*NPHASE + int'(item_q.phase)] + $signed({5'b0, item_q.dur_real});
          cur_d[1][w*NPHASE + int'(item_q.phase)] =
            cur_q[1][w*NPHASE + int'(item_q.phase)] + $signed({5'b0, item_q.dur_cpu});
        end
        tail_d  = inc(tail_q);
        w_d     = '0;
        d_d     = 1'b0;
        have_d  = 1'b0;
        state_d = ST_INIT;
      end

      // Start one slide: fill an open window or resume from the start pointer
      ST_INIT: begin
        if (!sval_q[d_q][w_q]) begin
          u_new = UW'(off) + UW'(nv);
          if (u_new < UW'(size)) begin
            soff_d[d_q][w_q] = u_new[TIME_W-1:0];
            cand       = head_q;
            slide_done = 1'b1;
          end else begin
            i_d      = head_q;
            u_d      = u_new;
            addoff_d = 1'b0;
            state_d  = ST_READ;
          end
        end else begin
          i_d      = sidx_q[d_q][w_q];
          u_d      = UW'(size) + UW'(nv) + UW'(off);
          addoff_d = 1'b1;
          state_d  = ST_READ;
        end
      end

      // Wait for the registered read of entry i
      ST_READ: begin
        state_d = ST_EVAL;
      end

      // Drop the entry if it fell out, else settle the partial start entry
      ST_EVAL: begin
        delta = addoff_q ? $signed({5'b0, off}) : '0;
        if (cont) begin
          delta    = delta - $signed({5'b0, e});
          u_d      = u_q - UW'(e);
          i_d      = inc(i_q);
          addoff_d = 1'b0;
          state_d  = ST_READ;
        end else begin
          delta = delta - $signed({2'b0, u_less});
          sidx_d[d_q][w_q] = i_q;
          sval_d[d_q][w_q] = 1'b1;
          soff_d[d_q][w_q] = (|u_less[UW-1:TIME_W]) ? MAX31 : u_less[TIME_W-1:0];
          cand       = i_q;
          slide_done = 1'b1;
        end
        cur_d[d_q][k] = cur_q[d_q][k] + delta;
      end

      // Move the head, clamp the sums, track min and max of full windows
      ST_UPDATE: begin
        if (have_q) begin
          head_d = newhead_q;
        end
        for (int w = 0; w < WINDOW_COUNT; w++) begin
          for (int p = 0; p < NPHASE; p++) begin
            for (int dd = 0; dd < 2; dd++) begin
              c = clamp31(cur_q[dd][w*NPHASE + p]);
              cur_d[dd][w*NPHASE + p] = $signed({5'b0, c});
              if (sval_q[0][w] && sval_q[1][w]) begin
                if (c < min_q[dd][w*NPHASE + p]) min_d[dd][w*NPHASE + p] = c;
                if (c > max_q[dd][w*NPHASE + p]) max_d[dd][w*NPHASE + p] = c;
              end
            end
          end
        end
        row_d   = '0;
        rw_d    = '0;
        rp_d    = '0;
        state_d = ST_EMIT;
      end

      // Put out one row per cycle
      ST_EMIT: begin
        row_d = row_q + NW'(1);
        if (rp_q == PHASE_W'(NPHASE - 1)) begin
          rp_d = '0;
          rw_d = rw_q + WW'(1);
        end else begin
          rp_d = rp_q + PHASE_W'(1);
        end
        if (row_q == NW'(NE - 1)) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Close a slide: keep the oldest start still needed, step to the next one
    age = ({1'b0, cand} >= {1'b0, head_q}) ? {1'b0, cand} - {1'b0, head_q} :
          {1'b0, cand} + (AW+1)'(LOG_DEPTH) - {1'b0, head_q};
    if (slide_done) begin
      if (!have_q || (age < best_q)) begin
        best_d    = age;
        newhead_d = cand;
        have_d    = 1'b1;
      end
      if (!d_q) begin
        d_d     = 1'b1;
        state_d = ST_INIT;
      end else if (w_q == WW'(WINDOW_COUNT - 1)) begin
        state_d = ST_UPDATE;
      end else begin
        d_d     = 1'b0;
        w_d     = w_q + WW'(1);
        state_d = ST_INIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      for (int w = 0; w < WINDOW_COUNT; w++) begin
        for (int dd = 0; dd < 2; dd++) begin
          sidx_q[dd][w] <= '0;
          sval_q[dd][w] <= 1'b0;
          soff_q[dd][w] <= '0;
        end
      end
      for (int n = 0; n < NE; n++) begin
        for (int dd = 0; dd < 2; dd++) begin
          cur_q[dd][n] <= '0;
          min_q[dd][n] <= MAX31;
          max_q[dd][n] <= '0;
        end
      end
      ovf_q    <= 1'b0;
      w_q      <= '0;
      d_q      <= 1'b0;
      addoff_q <= 1'b0;
      have_q   <= 1'b0;
      row_q    <= '0;
      rw_q     <= '0;
      rp_q     <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      sidx_q   <= sidx_d;
      sval_q   <= sval_d;
      soff_q   <= soff_d;
      cur_q    <= cur_d;
      min_q    <= min_d;
      max_q    <= max_d;
      ovf_q    <= ovf_d;
      w_q      <= w_d;
      d_q      <= d_d;
      addoff_q <= addoff_d;
      have_q   <= have_d;
      row_q    <= row_d;
      rw_q     <= rw_d;
      rp_q     <= rp_d;
    end
  end

  // Payload of the slide in progress
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    i_q       <= i_d;
    u_q       <= u_d;
    best_q    <= best_d;
    newhead_q <= newhead_d;
  end

  assign busy_o = (state_q != ST_IDLE);

  // Report row
  assign result_valid_o        = (state_q == ST_EMIT);
  assign result_o.window_index = 3'(rw_q);
  assign result_o.phase_index  = rp_q;
  assign result_o.cur_real     = clamp31(cur_q[0][row_q]);
  assign result_o.lo_real      = min_q[0][row_q];
  assign result_o.hi_real      = max_q[0][row_q];
  assign result_o.cur_cpu      = clamp31(cur_q[1][row_q]);
  assign result_o.min_cpu      = min_q[1][row_q];
  assign result_o.max_cpu      = max_q[1][row_q];
  assign result_o.window_full  = sval_q[0][rw_q] && sval_q[1][rw_q];
  assign result_o.log_overflow = ovf_q;
  assign result_o.last_row     = (row_q == NW'(NE - 1));

endmodule
